FILE: hw/rtl/wsfd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result kinds,
// opcodes, the result record and reset values. No dependencies.
package wsfd_pkg;

	localparam int CountWidthDef = 24;
	localparam int MaxPayloadW   = 24;
	localparam logic [MaxPayloadW-1:0] MaxPayloadRst = 24'h10_0000;

	localparam int AccW = 32;

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_STOP = 3'd5;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_BIG   = 2'd3;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic       fin;
		logic [3:0] opcode;
		logic [1:0] kind;
		logic       last;
		logic [7:0] data;
	} res_t;

endpackage

FILE: hw/rtl/wsfd_out_fifo.sv
// Two-entry result queue between the parser and the output stream.
// Depends on wsfd_pkg for the result record.
module wsfd_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsfd_pkg::res_t push_data,
	output logic          room,
	output logic          pop_valid,
	input  logic          pop_ready,
	output wsfd_pkg::res_t pop_data
);
	import wsfd_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign room      = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/wsfd_parser.sv
// Frame parser: input byte register, header/length/key/payload state and the
// per-byte decision that yields at most one result. Depends on wsfd_pkg.
module wsfd_parser #(
	parameter int COUNT_WIDTH = wsfd_pkg::CountWidthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_byte,
	input  logic                            cfg_we,
	input  logic [wsfd_pkg::MaxPayloadW-1:0] cfg_data,
	input  logic                            out_room,
	output logic                            res_push,
	output wsfd_pkg::res_t                  res
);
	import wsfd_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   adv;

	logic [MaxPayloadW-1:0] max_payload_q;
	logic [2:0]             phase_q, phase_d;
	logic [3:0]             opcode_q, opcode_d;
	logic                   fin_q, fin_d;
	logic                   masked_q, masked_d;
	logic [2:0]             left_q, left_d;
	logic [AccW-1:0]        acc_q, acc_d;
	logic                   hi_q, hi_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             idx_q, idx_d;
	logic [COUNT_WIDTH-1:0] pl_q, pl_d, pl_dec;

	logic                   len_done;
	logic                   hdr_done;
	logic                   delivers;
	logic                   emit;
	logic [7:0]             key_byte;
	logic [1:0]             kind;
	logic [7:0]             data;
	logic                   last;

	assign delivers = (opcode_q == OP_TEXT) || (opcode_q == OP_BIN) || (opcode_q == OP_PING);
	assign key_byte = 8'(key_q >> {~idx_q, 3'b000});
	assign pl_dec   = pl_q - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		masked_d = masked_q;
		left_d   = left_q;
		acc_d    = acc_q;
		hi_d     = hi_q;
		key_d    = key_q;
		idx_d    = idx_q;
		pl_d     = pl_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		emit     = 1'b0;
		kind     = KIND_BYTE;
		data     = 8'd0;
		last     = 1'b0;
		case (phase_q)
			PH_HDR0: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = byte_s1[7];
				acc_d    = '0;
				hi_d     = 1'b0;
				if (byte_s1[6:0] == LEN_EXT16) begin
					left_d  = 3'd1;
					phase_d = PH_EXT;
				end else if (byte_s1[6:0] == LEN_EXT64) begin
					left_d  = 3'd7;
					phase_d = PH_EXT;
				end else begin
					acc_d    = {{(AccW-7){1'b0}}, byte_s1[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				hi_d  = hi_q || (acc_q[AccW-1:AccW-8] != 8'd0);
				acc_d = {acc_q[AccW-9:0], byte_s1};
				if (left_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					left_d = left_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				if (left_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					left_d = left_q - 3'd1;
				end
			end
			PH_DATA: begin
				data  = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
				idx_d = idx_q + 2'd1;
				pl_d  = pl_dec;
				last  = (pl_dec == '0);
				if (last) begin
					phase_d = PH_HDR0;
				end
				if (delivers) begin
					emit = 1'b1;
					kind = KIND_BYTE;
				end else if (opcode_q == OP_CLOSE && last) begin
					emit    = 1'b1;
					kind    = KIND_CLOSE;
					data    = 8'd0;
					phase_d = PH_STOP;
				end
			end
			default: begin
				phase_d = PH_STOP;
			end
		endcase

		if (len_done) begin
			if (masked_d) begin
				left_d  = 3'd3;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			if (hi_d || (acc_d > {{(AccW-MaxPayloadW){1'b0}}, max_payload_q})
					|| ((acc_d >> COUNT_WIDTH) != '0)) begin
				phase_d = PH_STOP;
				emit    = 1'b1;
				kind    = KIND_BIG;
				last    = 1'b0;
			end else if (acc_d == '0) begin
				phase_d = PH_HDR0;
				if (opcode_q == OP_CLOSE) begin
					phase_d = PH_STOP;
					emit    = 1'b1;
					kind    = KIND_CLOSE;
					last    = 1'b1;
				end else if (delivers) begin
					emit = 1'b1;
					kind = KIND_EMPTY;
					last = 1'b1;
				end
			end else begin
				pl_d    = acc_d[COUNT_WIDTH-1:0];
				idx_d   = 2'd0;
				phase_d = PH_DATA;
			end
		end
	end

	assign adv      = valid_s1 && (!emit || out_room);
	assign in_ready = !valid_s1 || adv;
	assign res_push = adv && emit;

	always_comb begin
		res.fin    = fin_q;
		res.opcode = opcode_q;
		res.kind   = kind;
		res.last   = last;
		res.data   = data;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			max_payload_q <= MaxPayloadRst;
			phase_q       <= PH_HDR0;
			opcode_q      <= 4'd0;
			fin_q         <= 1'b0;
			masked_q      <= 1'b0;
			left_q        <= 3'd0;
			acc_q         <= '0;
			hi_q          <= 1'b0;
			key_q         <= '0;
			idx_q         <= 2'd0;
			pl_q          <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				max_payload_q <= cfg_data;
			end
			if (adv) begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				fin_q    <= fin_d;
				masked_q <= masked_d;
				left_q   <= left_d;
				acc_q    <= acc_d;
				hi_q     <= hi_d;
				key_q    <= key_d;
				idx_q    <= idx_d;
				pl_q     <= pl_d;
			end
		end
	end

endmodule

FILE: hw/rtl/websocket_frame_deframer_unit.sv
// WebSocket frame deframer, top level: one received byte per request.
// A result passes through the input byte register and the result queue before it is shown on m_*.
// Throughput: one byte every cycle while the result queue has room, set by the single-pass parse between the
// input byte register and the two-entry result queue.
// Reset (arst_n low): parser to first header byte, state cleared,
// max_payload to 1048576, queue emptied. Depends on wsfd_pkg, wsfd_parser, wsfd_out_fifo.
module websocket_frame_deframer_unit #(
	parameter int COUNT_WIDTH = wsfd_pkg::CountWidthDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [7:0] data
	output logic [6:0]                       m_tuser,   // [1:0] kind, [5:2] opcode, [6] fin
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wsfd_pkg::MaxPayloadW-1:0] cfg_data   // max_payload
);
	import wsfd_pkg::*;

	logic room;
	logic push;
	res_t push_res;
	res_t head;

	assign cfg_ready = 1'b1;

	wsfd_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_room (room),
		.res_push (push),
		.res      (push_res)
	);

	wsfd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_res),
		.room      (room),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_data  (head)
	);

	assign m_tdata = head.data;
	assign m_tuser = {head.fin, head.opcode, head.kind};
	assign m_tlast = head.last;

endmodule

FILE: tb/websocket_frame_deframer_unit_test.sv
// Testbench for websocket_frame_deframer_unit: builds WebSocket frames byte by byte,
// predicts every deframed result and checks it on the result stream.
// Depends on wsfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_test;
	import wsfd_pkg::*;

	localparam logic [3:0]  OP_PONG   = 4'hA;
	localparam logic [63:0] COUNT_MAX = (64'd1 << CountWidthDef) - 64'd1;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [6:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data  = 24'h0;

	logic [7:0] wire_q[$];
	res_t       deframed_q[$];
	int         fed;
	int         errors;

	// parser shadow
	logic [2:0]  ph_r;
	logic [3:0]  op_r;
	logic        fin_r;
	logic        masked_r;
	logic [2:0]  field_left;
	logic [63:0] len_acc;
	logic [31:0] key_r;
	logic [1:0]  key_pos;
	logic [23:0] left_r;
	logic [23:0] limit_r;

	int   in_gap;
	int   in_lim;
	int   out_hold;
	int   out_lim;
	logic s_next;

	websocket_frame_deframer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (errors < 100)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void add_result(input logic [1:0] k, input logic [7:0] d,
			input logic l);
		res_t r;
		r.kind   = k;
		r.data   = d;
		r.opcode = op_r;
		r.last   = l;
		r.fin    = fin_r;
		deframed_q.insert(deframed_q.size(), r);
	endfunction

	function automatic bit op_delivers();
		return op_r == OP_TEXT || op_r == OP_BIN || op_r == OP_PING;
	endfunction

	function automatic void header_complete();
		if (len_acc > {40'h0, limit_r} || len_acc > COUNT_MAX) begin
			ph_r = PH_STOP;
			add_result(KIND_BIG, 8'h00, 1'b0);
		end else if (len_acc == 64'h0) begin
			ph_r = PH_HDR0;
			if (op_r == OP_CLOSE) begin
				ph_r = PH_STOP;
				add_result(KIND_CLOSE, 8'h00, 1'b1);
			end else if (op_delivers()) begin
				add_result(KIND_EMPTY, 8'h00, 1'b1);
			end
		end else begin
			left_r  = len_acc[23:0];
			key_pos = 2'd0;
			ph_r    = PH_DATA;
		end
	endfunction

	function automatic void length_complete();
		if (masked_r) begin
			key_r      = 32'h0;
			field_left = 3'd3;
			ph_r       = PH_KEY;
		end else begin
			header_complete();
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic [7:0] d;
		logic       lst;
		int         sh;
		case (ph_r)
			PH_HDR0: begin
				fin_r = b[7];
				op_r  = b[3:0];
				ph_r  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_r = b[7];
				len_acc  = 64'h0;
				if (b[6:0] == LEN_EXT16) begin
					field_left = 3'd1;
					ph_r       = PH_EXT;
				end else if (b[6:0] == LEN_EXT64) begin
					field_left = 3'd7;
					ph_r       = PH_EXT;
				end else begin
					len_acc = {57'h0, b[6:0]};
					length_complete();
				end
			end
			PH_EXT: begin
				len_acc = {len_acc[55:0], b};
				if (field_left == 3'd0)
					length_complete();
				else
					field_left = field_left - 3'd1;
			end
			PH_KEY: begin
				key_r = {key_r[23:0], b};
				if (field_left == 3'd0)
					header_complete();
				else
					field_left = field_left - 3'd1;
			end
			PH_DATA: begin
				d = b;
				if (masked_r) begin
					sh = 24 - 8 * key_pos;
					d  = d ^ key_r[sh +: 8];
				end
				key_pos = key_pos + 2'd1;
				left_r  = left_r - 24'd1;
				lst     = (left_r == 24'd0);
				if (lst)
					ph_r = PH_HDR0;
				if (op_delivers()) begin
					add_result(KIND_BYTE, d, lst);
				end else if (op_r == OP_CLOSE && lst) begin
					ph_r = PH_STOP;
					add_result(KIND_CLOSE, 8'h00, 1'b1);
				end
			end
			default: ph_r = PH_STOP;
		endcase
	endfunction

	function automatic int draw_lim();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 2;
			default: return 18;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
		end else begin
			s_next = s_tvalid;
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				s_next = 1'b0;
			end
			if (!s_next) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (wire_q.size() != 0) begin
					s_tdata <= wire_q.pop_front();
					s_next = 1'b1;
					if ($urandom_range(0, 39) == 0)
						in_lim = draw_lim();
					in_gap = $urandom_range(0, in_lim);
				end
			end
			s_tvalid <= s_next;
		end
	end

	task automatic check_result();
		res_t w;
		if (deframed_q.size() == 0) begin
			report_mismatch($sformatf("result with none pending: tuser %h tdata %h",
				m_tuser, m_tdata));
		end else begin
			w = deframed_q.pop_front();
			if (m_tuser[1:0] != w.kind)
				report_mismatch($sformatf("kind %0d, want %0d", m_tuser[1:0], w.kind));
			if (m_tdata != w.data)
				report_mismatch($sformatf("data %h, want %h", m_tdata, w.data));
			if (m_tuser[5:2] != w.opcode)
				report_mismatch($sformatf("opcode %h, want %h", m_tuser[5:2], w.opcode));
			if (m_tlast != w.last)
				report_mismatch($sformatf("last %0b, want %0b", m_tlast, w.last));
			if (m_tuser[6] != w.fin)
				report_mismatch($sformatf("fin %0b, want %0b", m_tuser[6], w.fin));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
				if ($urandom_range(0, 39) == 0)
					out_lim = draw_lim();
				out_hold = $urandom_range(0, out_lim);
			end
			if (out_hold > 0) begin
				out_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic feed(input logic [7:0] b);
		wire_q.insert(wire_q.size(), b);
		fed++;
	endtask

	// form: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
	task automatic queue_frame(input logic [3:0] op, input logic [63:0] len, input bit masked,
			input int form, input int body);
		logic fin_b;
		fin_b = 1'($urandom_range(0, 1));
		feed({fin_b, 3'($urandom_range(0, 7)), op});
		if (form == 0) begin
			feed({masked, len[6:0]});
		end else if (form == 1) begin
			feed({masked, LEN_EXT16});
			feed(len[15:8]);
			feed(len[7:0]);
		end else begin
			feed({masked, LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				feed(len[8 * i +: 8]);
		end
		if (masked)
			repeat (4) feed(8'($urandom_range(0, 255)));
		repeat (body) feed(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_random_frame(input int cap);
		logic [3:0] op;
		int         pick;
		int         len;
		int         form;
		pick = $urandom_range(0, 9);
		if (pick <= 2)
			op = OP_TEXT;
		else if (pick <= 4)
			op = OP_BIN;
		else if (pick <= 6)
			op = OP_PING;
		else if (pick == 7)
			op = OP_PONG;
		else
			do op = 4'($urandom_range(0, 15)); while (op == OP_CLOSE);
		pick = $urandom_range(0, 19);
		if (pick <= 1)
			len = 0;
		else if (pick <= 15)
			len = $urandom_range(1, 20);
		else if (pick <= 18)
			len = $urandom_range(21, 125);
		else
			len = $urandom_range(126, 400);
		if (len > cap)
			len = $urandom_range(0, cap);
		if (cap <= 400 && $urandom_range(0, 7) == 0)
			len = cap;
		if (len <= 125) begin
			pick = $urandom_range(0, 5);
			form = (pick <= 3) ? 0 : pick - 3;
		end else begin
			form = $urandom_range(1, 2);
		end
		queue_frame(op, 64'(len), 1'($urandom_range(0, 1)), form, len);
	endtask

	task automatic queue_random_bytes(input int n, input int cap);
		int start;
		start = fed;
		while (fed - start < n)
			queue_random_frame(cap);
	endtask

	task automatic settle();
		@(negedge clk);
		while (wire_q.size() != 0 || s_tvalid || deframed_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [23:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_r = v;
	endtask

	initial begin
		logic [7:0]  seq[$];
		logic [23:0] lim;
		logic [63:0] big_len;
		ph_r       = PH_HDR0;
		op_r       = 4'h0;
		fin_r      = 1'b0;
		masked_r   = 1'b0;
		field_left = 3'd0;
		len_acc    = 64'h0;
		key_r      = 32'h0;
		key_pos    = 2'd0;
		left_r     = 24'h0;
		limit_r    = MaxPayloadRst;
		fed        = 0;
		errors     = 0;
		in_gap     = 0;
		out_hold   = 0;
		in_lim     = 18;
		out_lim    = 18;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty text, masked ping, 16-bit binary, silent pong, reserved opcode,
		// masked 64-bit binary
		seq = '{8'h81, 8'h00,
			8'h09, 8'h83, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h00, 8'hFF, 8'h5A,
			8'h02, 8'h7E, 8'h00, 8'h02, 8'h80, 8'h7F,
			8'h8A, 8'h01, 8'hFF,
			8'hF3, 8'h00,
			8'h82, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h01, 8'h02, 8'h03, 8'h04, 8'h11};
		foreach (seq[i])
			feed(seq[i]);
		settle();

		write_limit(24'hFF_FFFF);
		queue_random_bytes(220, 1000);
		settle();

		write_limit(24'h0);
		queue_random_bytes(60, 0);
		settle();

		lim = 24'($urandom_range(1, 64));
		write_limit(lim);
		queue_random_bytes(200, int'(lim));
		settle();

		lim = 24'($urandom_range(100, 5000));
		write_limit(lim);
		queue_random_bytes(200, 400);

		// end on a frame that halts the parser, then trailing bytes it must drop
		case ($urandom_range(0, 3))
			0: queue_frame(OP_CLOSE, 64'd0, 1'($urandom_range(0, 1)),
				$urandom_range(0, 2), 0);
			1: begin
				big_len = 64'($urandom_range(1, 10));
				queue_frame(OP_CLOSE, big_len, 1'($urandom_range(0, 1)), 0,
					int'(big_len));
			end
			2: queue_frame(OP_TEXT, {40'h0, lim} + 64'($urandom_range(1, 3)),
				1'($urandom_range(0, 1)), $urandom_range(1, 2), 0);
			default: begin
				big_len = {1'b1, 31'($urandom()), 32'($urandom())};
				queue_frame(OP_BIN, big_len, 1'($urandom_range(0, 1)), 2, 0);
			end
		endcase
		repeat (16) feed(8'($urandom_range(0, 255)));
		settle();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: websocket_frame_deframer_unit.f
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_out_fifo.sv
hw/rtl/wsfd_parser.sv
hw/rtl/websocket_frame_deframer_unit.sv
tb/websocket_frame_deframer_unit_test.sv
